@@ design/rpea_pkg.sv @@
// ----------------------------------------------------------------------------
// rpea_pkg
// Shared types, codes and constants for the radio packet energy accounting block.
// ----------------------------------------------------------------------------
package rpea_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_TX_HIGH  = 3'd0,
    CMD_TX_LOW   = 3'd1,
    CMD_CONNECT  = 3'd2,
    CMD_DISCONN  = 3'd3,
    CMD_SAMPLE   = 3'd4,
    CMD_SETPARAM = 3'd5,
    CMD_FLUSH    = 3'd6,
    CMD_RESTART  = 3'd7
  } cmd_t;

  localparam logic [1:0] REG_ADV_IVL = 2'd0;
  localparam logic [1:0] REG_PWR_OPT = 2'd1;
  localparam logic [1:0] REG_PKT_BUD = 2'd2;
  localparam logic [1:0] REG_SMP_BUD = 2'd3;

  localparam logic [13:0] ADV_IVL_RST = 14'd1000;
  localparam logic [31:0] PKT_BUD_RST = 32'd16200000;
  localparam logic [31:0] SMP_BUD_RST = 32'd6660000;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_seconds;
    logic [11:0] interval_units;
    logic [8:0]  periph_latency;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] adv_packets;
    logic [31:0] connected_packets;
    logic [31:0] connect_total;
    logic [31:0] sample_total;
    logic [7:0]  usage_percent;
    logic        is_connected;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_EST_MUL,
    ST_EST_DIV,
    ST_EST_WAIT,
    ST_SCL_DIV,
    ST_SCL_WAIT,
    ST_EST_ADD,
    ST_PKT_DIV,
    ST_PKT_WAIT,
    ST_PKT_DIV2,
    ST_PKT_WAIT2,
    ST_SMP_DIV,
    ST_SMP_WAIT,
    ST_SMP_DIV2,
    ST_SMP_WAIT2
  } state_t;

  // Operand selections for the divider.
  typedef enum logic [2:0] {
    DSEL_EST,
    DSEL_PKT,
    DSEL_PKT2,
    DSEL_SMP,
    DSEL_SMP2
  } dsel_t;

  typedef struct packed {
    logic  ev_load;
    logic  ev_apply;
    logic  est_mul;
    logic  div_start;
    dsel_t div_sel;
    logic  est_take_q;
    logic  scl_take_q;
    logic  scl_mul;
    logic  scl_load;
    logic  est_add;
    logic  term_take;
    logic  term_zero;
    logic  out_load;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic need_est;
    logic est_valid;
    logic scale_on;
    logic pkt_nz;
    logic smp_nz;
    logic q_zero;
  } stat_t;

endpackage

@@ design/rpea_div.sv @@
// ----------------------------------------------------------------------------
// rpea_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpea_div import rpea_pkg::*; #(
  parameter int unsigned W = DATA_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt, d_r, d_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[W-1:0], q_r[W-1]};
    if (start) begin
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

@@ design/rpea_datapath.sv @@
// ----------------------------------------------------------------------------
// rpea_datapath
// Event state, counters, estimate arithmetic and usage percent.
// ----------------------------------------------------------------------------
module rpea_datapath import rpea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctrl,
  output stat_t       stat,
  input  in_beat_t    in_beat,
  input  logic [13:0] adv_ivl,
  input  logic        pwr_opt,
  input  logic [31:0] pkt_bud,
  input  logic [31:0] smp_bud,
  output out_beat_t   out_beat
);
  in_beat_t    ev_r;
  logic [31:0] last_r, adv_r, conn_r, cev_r, smp_r;
  logic        conn_f_r, txh_r;
  logic [11:0] ivl_r;
  logic [8:0]  lat_r;
  logic [31:0] prod_r, dvs_r, n_r, scl_p_r;
  logic [7:0]  pct_r;
  out_beat_t   out_r;

  logic [31:0] dv_a, dv_b, quo;
  logic        ddone;
  logic [31:0] elapsed, pkt_sum;
  logic        scale_on;
  logic [63:0] scl_prod;

  assign elapsed  = ev_r.now_seconds - last_r;
  assign pkt_sum  = adv_r + conn_r;
  assign scale_on = pwr_opt & txh_r;
  // divide by 10 as multiply by ceil(2^35/10), shift by 35
  assign scl_prod = {32'd0, scl_p_r} * 64'h0000_0000_CCCC_CCCD;

  always_comb begin
    case (ctrl.div_sel)
      DSEL_EST:   begin dv_a = prod_r;  dv_b = dvs_r; end
      DSEL_PKT:   begin dv_a = pkt_bud; dv_b = pkt_sum; end
      DSEL_SMP:   begin dv_a = smp_bud; dv_b = smp_r; end
      default:    begin dv_a = 32'd100; dv_b = n_r; end
    endcase
  end

  rpea_div #(.W(DATA_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(ctrl.div_start),
    .dividend(dv_a), .divisor(dv_b), .done(ddone), .quotient(quo)
  );

  always_comb begin
    stat.div_done = ddone;
    stat.scale_on = scale_on;
    stat.pkt_nz   = pkt_sum != '0;
    stat.smp_nz   = smp_r != '0;
    stat.q_zero   = quo == '0;
    stat.est_valid = conn_f_r ? (ivl_r != '0) : (adv_ivl != '0);
    case (cmd_t'(ev_r.command))
      CMD_TX_HIGH: stat.need_est = pwr_opt & ~txh_r;
      CMD_TX_LOW:  stat.need_est = pwr_opt & txh_r;
      CMD_CONNECT, CMD_DISCONN, CMD_FLUSH: stat.need_est = 1'b1;
      default:     stat.need_est = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0; adv_r <= '0; conn_r <= '0; cev_r <= '0; smp_r <= '0;
      conn_f_r <= 1'b0; txh_r <= 1'b0; ivl_r <= '0; lat_r <= '0;
    end else begin
      if (ctrl.est_add) begin
        if (stat.est_valid) begin
          if (conn_f_r) conn_r <= conn_r + n_r;
          else          adv_r  <= adv_r + n_r;
        end
        last_r <= ev_r.now_seconds;
      end
      if (ctrl.ev_apply) begin
        case (cmd_t'(ev_r.command))
          CMD_TX_HIGH: if (pwr_opt) txh_r <= 1'b1;
          CMD_TX_LOW:  if (pwr_opt) txh_r <= 1'b0;
          CMD_CONNECT: begin
            cev_r    <= cev_r + 32'd1;
            conn_r   <= conn_r + (scale_on ? 32'd55 : 32'd50);
            conn_f_r <= 1'b1;
          end
          CMD_DISCONN: begin
            conn_f_r <= 1'b0; ivl_r <= '0; lat_r <= '0;
          end
          CMD_SAMPLE:   smp_r <= smp_r + 32'd1;
          CMD_SETPARAM: begin
            ivl_r <= ev_r.interval_units; lat_r <= ev_r.periph_latency;
          end
          CMD_RESTART: begin
            adv_r <= '0; conn_r <= '0; cev_r <= '0; smp_r <= '0;
            last_r <= ev_r.now_seconds;
          end
          default: ;
        endcase
      end
    end
    if (ctrl.ev_load) ev_r <= in_beat;
    if (ctrl.est_mul) begin
      prod_r <= conn_f_r ? elapsed * 32'd800 : elapsed * 32'd1000;
      dvs_r  <= conn_f_r ? {20'd0, ivl_r} * ({23'd0, lat_r} + 32'd1)
                         : {18'd0, adv_ivl};
    end
    if (ctrl.scl_mul) scl_p_r <= n_r * 32'd11;
    if (ctrl.scl_load) n_r <= {3'd0, scl_prod[63:35]};
    else if (ctrl.est_take_q || ctrl.scl_take_q) n_r <= quo;
    if (ctrl.ev_load) pct_r <= '0;
    else if (ctrl.term_zero) pct_r <= pct_r + 8'd100;
    else if (ctrl.term_take) pct_r <= pct_r + quo[7:0];
    if (ctrl.out_load) begin
      out_r.adv_packets       <= adv_r;
      out_r.connected_packets <= conn_r;
      out_r.connect_total     <= cev_r;
      out_r.sample_total      <= smp_r;
      out_r.usage_percent     <= pct_r;
      out_r.is_connected      <= conn_f_r;
    end
  end

  assign out_beat = out_r;
endmodule

@@ design/rpea_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpea_ctrl
// Sequencer for one event: estimate, apply, usage terms, result beat.
// ----------------------------------------------------------------------------
module rpea_ctrl import rpea_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);
  state_t st_r, st_nxt;
  logic   ov_r, ov_nxt;
  logic   done_gate, sdone_r, sdone_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    ctrl     = '0;
    ctrl.div_sel = DSEL_EST;
    ov_nxt   = ov_r & out_stall;
    in_stall = (st_r != ST_IDLE);
    case (st_r)
      ST_IDLE: if (in_valid) begin
        ctrl.ev_load = 1'b1;
        st_nxt = ST_EVENT;
      end
      ST_EVENT: begin
        ctrl.est_mul = 1'b1;
        st_nxt = (stat.need_est && stat.est_valid) ? ST_EST_MUL : ST_EST_ADD;
      end
      ST_EST_MUL: begin
        ctrl.div_start = 1'b1; ctrl.div_sel = DSEL_EST; st_nxt = ST_EST_WAIT;
      end
      ST_EST_WAIT: if (stat.div_done) begin
        ctrl.est_take_q = 1'b1;
        st_nxt = stat.scale_on ? ST_SCL_DIV : ST_EST_DIV;
      end
      ST_SCL_DIV: begin
        ctrl.scl_mul = 1'b1; st_nxt = ST_SCL_WAIT;
      end
      ST_SCL_WAIT: begin
        ctrl.scl_load = 1'b1; st_nxt = ST_EST_DIV;
      end
      ST_EST_DIV: begin
        ctrl.est_add = 1'b1; st_nxt = ST_EST_ADD;
      end
      ST_EST_ADD: begin
        ctrl.est_add = stat.need_est & ~stat.est_valid;
        ctrl.ev_apply = 1'b1; st_nxt = ST_PKT_DIV;
      end
      ST_PKT_DIV: begin
        if (stat.pkt_nz) begin
          ctrl.div_start = 1'b1; ctrl.div_sel = DSEL_PKT; st_nxt = ST_PKT_WAIT;
        end else st_nxt = ST_SMP_DIV;
      end
      ST_PKT_WAIT: if (stat.div_done) begin
        if (stat.q_zero) begin
          ctrl.term_zero = 1'b1; st_nxt = ST_SMP_DIV;
        end else begin
          ctrl.scl_take_q = 1'b1; st_nxt = ST_PKT_DIV2;
        end
      end
      ST_PKT_DIV2: begin
        ctrl.div_start = 1'b1; ctrl.div_sel = DSEL_PKT2; st_nxt = ST_PKT_WAIT2;
      end
      ST_PKT_WAIT2: if (stat.div_done) begin
        ctrl.term_take = 1'b1; st_nxt = ST_SMP_DIV;
      end
      ST_SMP_DIV: begin
        if (stat.smp_nz) begin
          ctrl.div_start = 1'b1; ctrl.div_sel = DSEL_SMP; st_nxt = ST_SMP_WAIT;
        end else if (!ov_r || !out_stall) begin
          ctrl.out_load = 1'b1; ov_nxt = 1'b1; st_nxt = ST_IDLE;
        end
      end
      ST_SMP_WAIT: if (stat.div_done) begin
        if (stat.q_zero) begin
          ctrl.term_zero = 1'b1; st_nxt = ST_SMP_WAIT2;
        end else begin
          ctrl.scl_take_q = 1'b1; st_nxt = ST_SMP_DIV2;
        end
      end
      ST_SMP_DIV2: begin
        ctrl.div_start = 1'b1; ctrl.div_sel = DSEL_SMP2; st_nxt = ST_SMP_WAIT2;
      end
      ST_SMP_WAIT2: begin
        if (stat.div_done) begin
          ctrl.term_take = 1'b1;
          st_nxt = ST_SMP_WAIT2;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    // Final hand-off, shared by both sample-term endings.
    if (st_r == ST_SMP_WAIT2 && !ctrl.term_take && done_gate) begin
      if (!ov_r || !out_stall) begin
        ctrl.out_load = 1'b1; ov_nxt = 1'b1; st_nxt = ST_IDLE;
      end
    end
  end

  // Gate for the last state: a term already added, or the zero term seen.
  always_comb begin
    sdone_nxt = sdone_r;
    if (st_r == ST_SMP_WAIT && stat.div_done && stat.q_zero) sdone_nxt = 1'b1;
    if (st_r == ST_SMP_WAIT2 && stat.div_done) sdone_nxt = 1'b1;
    if (st_r == ST_IDLE) sdone_nxt = 1'b0;
  end
  assign done_gate = sdone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sdone_r <= 1'b0;
    else        sdone_r <= sdone_nxt;
  end

  assign out_valid = ov_r;
endmodule

@@ design/radio_packet_energy_accounting_top.sv @@
// ----------------------------------------------------------------------------
// radio_packet_energy_accounting_top
// Radio event packet estimation and battery usage accounting.
//
//  channel | ports                         | beat
//  input   | in_valid/in_stall/in_beat     | in_beat_t
//  output  | out_valid/out_stall/out_beat  | out_beat_t
//  config  | cfg_psel..cfg_prdata (APB)    | 32-bit register
//
// One event uses up to five passes of the single shared serial divider
// (estimate, two per usage term), plus an 11/10 scale by reciprocal multiply.
// Synchronous active-low reset; no clearing pass. A waiting result beat is
// held in the output register; the next event may run, but its result waits
// for out_stall to drop.
// ----------------------------------------------------------------------------
module radio_packet_energy_accounting_top import rpea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [13:0] adv_ivl_r;
  logic        pwr_opt_r;
  logic [31:0] pkt_bud_r, smp_bud_r;
  logic [1:0]  ridx;
  logic        wr;
  ctrl_t       ctrl;
  stat_t       stat;

  assign ridx       = cfg_paddr[3:2];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_ivl_r <= ADV_IVL_RST;
      pwr_opt_r <= 1'b0;
      pkt_bud_r <= PKT_BUD_RST;
      smp_bud_r <= SMP_BUD_RST;
    end else if (wr) begin
      case (ridx)
        REG_ADV_IVL: adv_ivl_r <= cfg_pwdata[13:0];
        REG_PWR_OPT: pwr_opt_r <= cfg_pwdata[0];
        REG_PKT_BUD: pkt_bud_r <= cfg_pwdata;
        REG_SMP_BUD: smp_bud_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ADV_IVL: cfg_prdata = {18'd0, adv_ivl_r};
      REG_PWR_OPT: cfg_prdata = {31'd0, pwr_opt_r};
      REG_PKT_BUD: cfg_prdata = pkt_bud_r;
      default:     cfg_prdata = smp_bud_r;
    endcase
  end

  rpea_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  rpea_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .in_beat(in_beat),
    .adv_ivl(adv_ivl_r), .pwr_opt(pwr_opt_r), .pkt_bud(pkt_bud_r),
    .smp_bud(smp_bud_r), .out_beat(out_beat)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.usage_percent <= 8'd200)
    else $error("usage percent out of range");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> !ctrl.ev_load)
    else $error("load and accept collide");
`endif
endmodule
